// ===== rtl/smpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpr_pkg
// Shared constants, types and helpers for the symmetry-reduced rank block:
// the 24-row symmetry table, factorial digit weights and stage enables.
// ----------------------------------------------------------------------------
package smpr_pkg;

  localparam int unsigned NumLabels = 8;
  localparam int unsigned NumRows   = 24;
  localparam int unsigned NumDigits = 7;
  localparam int unsigned RankW     = 16;

  localparam logic [2:0] SYM_ROW [NumRows][NumLabels] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd2, 3'd6, 3'd4, 3'd7, 3'd5, 3'd1, 3'd3},
    '{3'd0, 3'd6, 3'd1, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4},
    '{3'd1, 3'd3, 3'd0, 3'd2, 3'd6, 3'd4, 3'd7, 3'd5},
    '{3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2},
    '{3'd1, 3'd7, 3'd3, 3'd5, 3'd2, 3'd4, 3'd0, 3'd6},
    '{3'd2, 3'd0, 3'd3, 3'd1, 3'd5, 3'd7, 3'd4, 3'd6},
    '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1},
    '{3'd2, 3'd4, 3'd0, 3'd6, 3'd1, 3'd7, 3'd3, 3'd5},
    '{3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4},
    '{3'd3, 3'd1, 3'd5, 3'd7, 3'd4, 3'd6, 3'd2, 3'd0},
    '{3'd3, 3'd5, 3'd2, 3'd4, 3'd0, 3'd6, 3'd1, 3'd7},
    '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd4, 3'd6, 3'd2, 3'd0, 3'd3, 3'd1, 3'd5, 3'd7},
    '{3'd4, 3'd2, 3'd5, 3'd3, 3'd7, 3'd1, 3'd6, 3'd0},
    '{3'd5, 3'd7, 3'd4, 3'd6, 3'd2, 3'd0, 3'd3, 3'd1},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6},
    '{3'd5, 3'd3, 3'd7, 3'd1, 3'd6, 3'd0, 3'd4, 3'd2},
    '{3'd6, 3'd4, 3'd7, 3'd5, 3'd1, 3'd3, 3'd0, 3'd2},
    '{3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd6, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd7, 3'd1},
    '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0},
    '{3'd7, 3'd5, 3'd1, 3'd3, 3'd0, 3'd2, 3'd6, 3'd4},
    '{3'd7, 3'd1, 3'd6, 3'd0, 3'd4, 3'd2, 3'd5, 3'd3}
  };

  localparam logic [RankW-1:0] DIGIT_WEIGHT [NumDigits] = '{
    16'd5040, 16'd720, 16'd120, 16'd24, 16'd6, 16'd2, 16'd1
  };

  typedef logic [2:0]       label_t;
  typedef logic [RankW-1:0] rank_t;

  typedef struct packed {
    logic load_pos;
    logic load_rank;
  } lane_en_t;

  typedef struct packed {
    logic load_grp;
    logic load_out;
  } merge_en_t;

  // Position of a label within one symmetry row.
  function automatic logic [2:0] row_pos(input logic [4:0] row, input logic [2:0] label);
    logic [2:0] pos;
    pos = '0;
    for (int q = 0; q < NumLabels; q++) begin
      if (SYM_ROW[row][q] == label) pos = 3'(q);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/smpr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpr_lane
// Ranks the permutation under one symmetry row. Stage one registers the row
// position of each relabeled entry, stage two the Lehmer-code rank.
// ----------------------------------------------------------------------------
module smpr_lane #(
  parameter int unsigned Row = 0
) (
  input  logic               clk_i,
  input  smpr_pkg::label_t   labels_i [smpr_pkg::NumLabels],
  input  smpr_pkg::lane_en_t en_i,
  output smpr_pkg::rank_t    rank_o
);

  logic [2:0]      pos_d [smpr_pkg::NumDigits];
  logic [2:0]      pos_q [smpr_pkg::NumDigits];
  smpr_pkg::rank_t rank_d, rank_q;

  always_comb begin
    for (int i = 0; i < smpr_pkg::NumDigits; i++) begin
      pos_d[i] = smpr_pkg::row_pos(5'(Row), labels_i[smpr_pkg::SYM_ROW[Row][i]]);
    end
  end

  // Digit is the row position less the earlier entries already taken before it.
  always_comb begin
    logic [2:0] digit;
    rank_d = '0;
    for (int i = 0; i < smpr_pkg::NumDigits; i++) begin
      digit = pos_q[i];
      for (int j = 0; j < i; j++) begin
        if (pos_q[j] < pos_q[i]) digit = digit - 3'd1;
      end
      rank_d = rank_d + (smpr_pkg::RankW'(digit) * smpr_pkg::DIGIT_WEIGHT[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_pos) begin
      pos_q <= pos_d;
    end
    if (en_i.load_rank) begin
      rank_q <= rank_d;
    end
  end

  assign rank_o = rank_q;

endmodule

// ===== rtl/smpr_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpr_merge
// Registered minimum tree over the lane ranks: groups of three first, then
// a tree over the eight group minima into the output register.
// ----------------------------------------------------------------------------
module smpr_merge (
  input  logic                clk_i,
  input  smpr_pkg::rank_t     ranks_i [smpr_pkg::NumRows],
  input  smpr_pkg::merge_en_t en_i,
  output smpr_pkg::rank_t     min_o
);

  localparam int unsigned NumGrp = smpr_pkg::NumRows / 3;

  function automatic smpr_pkg::rank_t min2(input smpr_pkg::rank_t a, input smpr_pkg::rank_t b);
    return (b < a) ? b : a;
  endfunction

  smpr_pkg::rank_t grp_d [NumGrp];
  smpr_pkg::rank_t grp_q [NumGrp];
  smpr_pkg::rank_t lvl1 [4];
  smpr_pkg::rank_t lvl2 [2];
  smpr_pkg::rank_t min_d, min_q;

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = min2(min2(ranks_i[3*g], ranks_i[3*g+1]), ranks_i[3*g+2]);
    end
    for (int k = 0; k < 4; k++) lvl1[k] = min2(grp_q[2*k], grp_q[2*k+1]);
    for (int k = 0; k < 2; k++) lvl2[k] = min2(lvl1[2*k], lvl1[2*k+1]);
    min_d = min2(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load_grp) begin
      grp_q <= grp_d;
    end
    if (en_i.load_out) begin
      min_q <= min_d;
    end
  end

  assign min_o = min_q;

endmodule

// ===== rtl/symmetry_min_permutation_rank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetry_min_permutation_rank
// Smallest factorial-base rank of an 8-label permutation over 24 symmetries.
//
// Input channel: label_0_i..label_7_i with in_valid_i / in_ready_o. Output
// channel: min_rank_o and not_permutation_o with out_valid_o / out_ready_i.
// A transaction moves on a rising edge where valid and ready are both high.
// Labels that repeat give not_permutation_o = 1 and min_rank_o = 0.
//
// Throughput: one transaction per cycle unless the receiver stalls.
// Twenty-four lanes rank the input in parallel, one per symmetry row, and a
// registered min tree merges them. Four register stages: row positions, lane
// rank, group minimum and final minimum in the output register. The first
// loads at acceptance; out_valid_o is high while the last one is full.
//
// Each of the four stages carries its own valid bit and accepts a new
// transaction whenever it is empty or the stage after it advances, so a
// stalled receiver only holds the stages that are full; bubbles fill in.
// Reset clears all valid bits; the pipeline comes out empty.
// ----------------------------------------------------------------------------
module symmetry_min_permutation_rank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  label_0_i,
  input  logic [2:0]  label_1_i,
  input  logic [2:0]  label_2_i,
  input  logic [2:0]  label_3_i,
  input  logic [2:0]  label_4_i,
  input  logic [2:0]  label_5_i,
  input  logic [2:0]  label_6_i,
  input  logic [2:0]  label_7_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [15:0] min_rank_o,
  output logic        not_permutation_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  smpr_pkg::label_t    labels [smpr_pkg::NumLabels];
  smpr_pkg::rank_t     lane_rank [smpr_pkg::NumRows];
  smpr_pkg::rank_t     merged;
  smpr_pkg::lane_en_t  lane_en;
  smpr_pkg::merge_en_t merge_en;

  logic v1_q, v2_q, v3_q, v4_q;
  logic bad1_q, bad2_q, bad3_q, bad4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic dup;

  assign labels[0] = label_0_i;
  assign labels[1] = label_1_i;
  assign labels[2] = label_2_i;
  assign labels[3] = label_3_i;
  assign labels[4] = label_4_i;
  assign labels[5] = label_5_i;
  assign labels[6] = label_6_i;
  assign labels[7] = label_7_i;

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < smpr_pkg::NumLabels; i++) begin
      for (int j = i + 1; j < smpr_pkg::NumLabels; j++) begin
        if (labels[i] == labels[j]) dup = 1'b1;
      end
    end
  end

  // Advance a stage when it is empty or its successor moves.
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o = rdy1;

  assign lane_en.load_pos   = rdy1;
  assign lane_en.load_rank  = rdy2;
  assign merge_en.load_grp  = rdy3;
  assign merge_en.load_out  = rdy4;

  for (genvar r = 0; r < smpr_pkg::NumRows; r++) begin : g_lane
    smpr_lane #(
      .Row (r)
    ) u_lane (
      .clk_i    (clk_i),
      .labels_i (labels),
      .en_i     (lane_en),
      .rank_o   (lane_rank[r])
    );
  end

  smpr_merge u_merge (
    .clk_i   (clk_i),
    .ranks_i (lane_rank),
    .en_i    (merge_en),
    .min_o   (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) bad1_q <= dup;
    if (rdy2) bad2_q <= bad1_q;
    if (rdy3) bad3_q <= bad2_q;
    if (rdy4) bad4_q <= bad3_q;
  end

  assign out_valid_o       = v4_q;
  assign not_permutation_o = bad4_q;
  assign min_rank_o        = bad4_q ? '0 : merged;

endmodule
